FILE: sv/esu_pkg.sv
// Shared types and constants for the escaped-string to UTF-8 converter.
`timescale 1ns / 1ps

package esu_pkg;

  // Scanner modes of the front end
  typedef enum logic [2:0] {
    M_NORMAL  = 3'd0,
    M_ESC     = 3'd1,
    M_XHEX    = 3'd2,
    M_UHEX    = 3'd3,
    M_WANT_BS = 3'd4,
    M_WANT_U  = 3'd5,
    M_LOWHEX  = 3'd6,
    M_SWALLOW = 3'd7
  } scan_mode_t;

  // What one character produces besides errors
  typedef enum logic [1:0] {
    EMIT_NONE = 2'd0,
    EMIT_BYTE = 2'd1,
    EMIT_UTF8 = 2'd2
  } emit_t;

  // Results of one character: 1..4 results, carried front to back
  typedef struct packed {
    logic [2:0]      cnt;     // number of results
    logic [3:0][7:0] data;    // data[0] goes out first
    logic            nodata;  // single result with byte_valid = 0
    logic            err;     // parse_error on the final result
    logic            eos;     // end_of_string on the final result
  } pkt_t;

  localparam logic [2:0] MAX_RESULTS = 3'd4;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CH_X      = 8'h78;

  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_FF = 8'h0C;
  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;

  localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
  localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
  localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  localparam logic [20:0] UTF8_LIM1 = 21'h00080;
  localparam logic [20:0] UTF8_LIM2 = 21'h00800;
  localparam logic [20:0] UTF8_LIM3 = 21'h10000;

endpackage

FILE: sv/escaped_string_to_utf8.sv
// Top level of the escaped-string to UTF-8 converter.
`timescale 1ns / 1ps
// A character's results pass through the packet queue and then the output registers on their way out.
// Throughput: one character per cycle; the output side moves one result byte per cycle while
//   out_stall is low, so a character with k results takes k output transactions (k = 1..4).
// Input stalls only when the QUEUE_DEPTH-entry packet queue is full.
// Reset (rst_n low, synchronous) returns the scanner to normal text and empties the queue.

module escaped_string_to_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  // character input
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_char_in,
  input  logic       in_char_last,
  // result output
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte_out,
  output logic       out_byte_valid,
  output logic       out_parse_error,
  output logic       out_end_of_string
);

  logic          accept;
  logic          push;
  esu_pkg::pkt_t pkt;
  esu_pkg::pkt_t head;
  logic          empty;
  logic          full;
  logic          pop;

  // stall comes from queue occupancy only, never from in_valid
  assign in_stall = full;
  assign accept   = in_valid && !in_stall;

  // Front: escape scanner, one character per transaction, packs 0..4 results
  esu_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept_i (accept),
    .char_i   (in_char_in),
    .last_i   (in_char_last),
    .push_o   (push),
    .pkt_o    (pkt)
  );

  // Queue decouples scanner from the byte emitter
  esu_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_i  (push),
    .pkt_i   (pkt),
    .pop_i   (pop),
    .head_o  (head),
    .empty_o (empty),
    .full_o  (full)
  );

  // Back: registered output, one result byte per transaction
  esu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head_i            (head),
    .empty_i           (empty),
    .pop_o             (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte_out      (out_byte_out),
    .out_byte_valid    (out_byte_valid),
    .out_parse_error   (out_parse_error),
    .out_end_of_string (out_end_of_string)
  );

endmodule

FILE: sv/esu_front.sv
// Front end: scans escaped characters and packs the results of each one.
`timescale 1ns / 1ps

module esu_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           accept_i,
  input  logic [7:0]     char_i,
  input  logic           last_i,
  output logic           push_o,
  output esu_pkg::pkt_t  pkt_o
);

  esu_pkg::scan_mode_t mode_r, mode_nxt;
  logic [2:0]  dig_r, dig_nxt;
  logic [15:0] acc_r, acc_nxt;
  logic [15:0] hs_r, hs_nxt;
  logic        err_r, err_nxt;

  // step decode results
  esu_pkg::scan_mode_t mode_c;
  logic [2:0]    dig_c;
  logic [15:0]   acc_c;
  logic [15:0]   hs_c;
  logic          fail_c;
  esu_pkg::emit_t emit_c;
  logic [7:0]    lit_c;
  logic [20:0]   cp_c;

  logic [4:0]  dv;
  logic        hex_ok;
  logic [15:0] acc_shift;
  logic [2:0]  dig_inc;
  logic        esc_ok;
  logic        is_alnum;
  logic        fail_all;
  logic        err_final;

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= 8'h30 && c <= 8'h39) v = 5'(c - 8'h30);
    else if (c >= 8'h41 && c <= 8'h46) v = 5'(c - 8'h37);
    else if (c >= 8'h61 && c <= 8'h66) v = 5'(c - 8'h57);
    return v;
  endfunction

  assign dv        = digit_value(char_i);
  assign hex_ok    = !dv[4];
  assign acc_shift = {acc_r[11:0], dv[3:0]};
  assign dig_inc   = dig_r + 3'd1;

  assign is_alnum = (char_i >= 8'h61 && char_i <= 8'h7A) ||
                    (char_i >= 8'h41 && char_i <= 8'h5A) ||
                    (char_i >= 8'h30 && char_i <= 8'h39);
  always_comb begin
    if (is_alnum) begin
      esc_ok = (char_i == esu_pkg::CH_B) || (char_i == esu_pkg::CH_F) ||
               (char_i == esu_pkg::CH_N) || (char_i == esu_pkg::CH_R) ||
               (char_i == esu_pkg::CH_T) || (char_i == esu_pkg::CH_U) ||
               (char_i == esu_pkg::CH_X);
    end else if (char_i <= esu_pkg::CH_SPACE) begin
      esc_ok = (char_i == esu_pkg::CH_SPACE);
    end else begin
      esc_ok = (char_i < esu_pkg::CH_DEL);
    end
  end

  // Per-character decode of the scanner
  always_comb begin
    mode_c = mode_r;
    dig_c  = dig_r;
    acc_c  = acc_r;
    hs_c   = hs_r;
    fail_c = 1'b0;
    emit_c = esu_pkg::EMIT_NONE;
    lit_c  = char_i;
    cp_c   = {5'd0, acc_shift};
    unique case (mode_r)
      esu_pkg::M_NORMAL: begin
        if (char_i == esu_pkg::CH_BSLASH) mode_c = esu_pkg::M_ESC;
        else emit_c = esu_pkg::EMIT_BYTE;
      end
      esu_pkg::M_ESC: begin
        if (!esc_ok) begin
          fail_c = 1'b1;
        end else begin
          mode_c = esu_pkg::M_NORMAL;
          dig_c  = 3'd0;
          acc_c  = 16'd0;
          emit_c = esu_pkg::EMIT_BYTE;
          priority if (char_i == esu_pkg::CH_B) lit_c = esu_pkg::BYTE_BS;
          else if (char_i == esu_pkg::CH_F) lit_c = esu_pkg::BYTE_FF;
          else if (char_i == esu_pkg::CH_N) lit_c = esu_pkg::BYTE_LF;
          else if (char_i == esu_pkg::CH_R) lit_c = esu_pkg::BYTE_CR;
          else if (char_i == esu_pkg::CH_T) lit_c = esu_pkg::BYTE_HT;
          else if (char_i == esu_pkg::CH_X) begin
            mode_c = esu_pkg::M_XHEX;
            emit_c = esu_pkg::EMIT_NONE;
          end else if (char_i == esu_pkg::CH_U) begin
            mode_c = esu_pkg::M_UHEX;
            emit_c = esu_pkg::EMIT_NONE;
          end else begin
            lit_c = char_i;
          end
        end
      end
      esu_pkg::M_XHEX: begin
        if (!hex_ok) begin
          fail_c = 1'b1;
        end else begin
          acc_c = acc_shift;
          dig_c = dig_inc;
          if (dig_inc >= 3'd2) begin
            lit_c  = acc_shift[7:0];
            emit_c = esu_pkg::EMIT_BYTE;
            mode_c = esu_pkg::M_NORMAL;
          end
        end
      end
      esu_pkg::M_UHEX, esu_pkg::M_LOWHEX: begin
        if (!hex_ok) begin
          fail_c = 1'b1;
        end else if (dig_inc < 3'd4) begin
          acc_c = acc_shift;
          dig_c = dig_inc;
        end else if (mode_r == esu_pkg::M_UHEX) begin
          if (acc_shift >= esu_pkg::SURR_HIGH_MIN && acc_shift <= esu_pkg::SURR_LOW_MAX) begin
            if (acc_shift >= esu_pkg::SURR_LOW_MIN) begin
              fail_c = 1'b1;   // lone low surrogate
            end else begin
              hs_c   = acc_shift;
              mode_c = esu_pkg::M_WANT_BS;
              dig_c  = 3'd0;
              acc_c  = 16'd0;
            end
          end else begin
            emit_c = esu_pkg::EMIT_UTF8;
            mode_c = esu_pkg::M_NORMAL;
            dig_c  = 3'd0;
            acc_c  = 16'd0;
          end
        end else begin
          if (acc_shift < esu_pkg::SURR_LOW_MIN || acc_shift > esu_pkg::SURR_LOW_MAX) begin
            fail_c = 1'b1;
          end else begin
            cp_c   = {1'b0, hs_r[9:0], acc_shift[9:0]} + esu_pkg::SUPP_BASE;
            emit_c = esu_pkg::EMIT_UTF8;
            mode_c = esu_pkg::M_NORMAL;
            dig_c  = 3'd0;
            acc_c  = 16'd0;
          end
        end
      end
      esu_pkg::M_WANT_BS: begin
        if (char_i == esu_pkg::CH_BSLASH) mode_c = esu_pkg::M_WANT_U;
        else fail_c = 1'b1;
      end
      esu_pkg::M_WANT_U: begin
        if (char_i == esu_pkg::CH_U) begin
          mode_c = esu_pkg::M_LOWHEX;
          dig_c  = 3'd0;
          acc_c  = 16'd0;
        end else begin
          fail_c = 1'b1;
        end
      end
      esu_pkg::M_SWALLOW: begin
      end
      default: begin
      end
    endcase
  end

  // unfinished escape on the last character is an error too
  assign fail_all  = fail_c || (last_i && mode_c != esu_pkg::M_NORMAL &&
                                mode_c != esu_pkg::M_SWALLOW);
  assign err_final = err_r | fail_all;

  // Next state
  always_comb begin
    mode_nxt = mode_r;
    dig_nxt  = dig_r;
    acc_nxt  = acc_r;
    hs_nxt   = hs_r;
    err_nxt  = err_r;
    if (accept_i) begin
      if (last_i) begin
        mode_nxt = esu_pkg::M_NORMAL;
        dig_nxt  = 3'd0;
        acc_nxt  = 16'd0;
        hs_nxt   = 16'd0;
        err_nxt  = 1'b0;
      end else begin
        mode_nxt = fail_all ? esu_pkg::M_SWALLOW : mode_c;
        dig_nxt  = dig_c;
        acc_nxt  = acc_c;
        hs_nxt   = hs_c;
        err_nxt  = err_final;
      end
    end
  end

  // Result packing
  always_comb begin
    pkt_o        = '0;
    pkt_o.cnt    = 3'd0;
    if (!fail_all) begin
      unique case (emit_c)
        esu_pkg::EMIT_BYTE: begin
          pkt_o.cnt     = 3'd1;
          pkt_o.data[0] = lit_c;
        end
        esu_pkg::EMIT_UTF8: begin
          if (cp_c < esu_pkg::UTF8_LIM1) begin
            pkt_o.cnt     = 3'd1;
            pkt_o.data[0] = cp_c[7:0];
          end else if (cp_c < esu_pkg::UTF8_LIM2) begin
            pkt_o.cnt     = 3'd2;
            pkt_o.data[0] = {3'b110, cp_c[10:6]};
            pkt_o.data[1] = {2'b10, cp_c[5:0]};
          end else if (cp_c < esu_pkg::UTF8_LIM3) begin
            pkt_o.cnt     = 3'd3;
            pkt_o.data[0] = {4'b1110, cp_c[15:12]};
            pkt_o.data[1] = {2'b10, cp_c[11:6]};
            pkt_o.data[2] = {2'b10, cp_c[5:0]};
          end else begin
            pkt_o.cnt     = esu_pkg::MAX_RESULTS;
            pkt_o.data[0] = {5'b11110, cp_c[20:18]};
            pkt_o.data[1] = {2'b10, cp_c[17:12]};
            pkt_o.data[2] = {2'b10, cp_c[11:6]};
            pkt_o.data[3] = {2'b10, cp_c[5:0]};
          end
        end
        esu_pkg::EMIT_NONE: begin
        end
        default: begin
        end
      endcase
    end
    if (fail_all && !last_i) begin
      pkt_o.cnt    = 3'd1;
      pkt_o.nodata = 1'b1;
      pkt_o.err    = 1'b1;
    end else if (last_i) begin
      pkt_o.eos = 1'b1;
      pkt_o.err = err_final;
      if (pkt_o.cnt == 3'd0) begin
        pkt_o.cnt    = 3'd1;
        pkt_o.nodata = 1'b1;
      end
    end
  end

  assign push_o = accept_i && (pkt_o.cnt != 3'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= esu_pkg::M_NORMAL;
      dig_r  <= 3'd0;
      acc_r  <= 16'd0;
      hs_r   <= 16'd0;
      err_r  <= 1'b0;
    end else begin
      mode_r <= mode_nxt;
      dig_r  <= dig_nxt;
      acc_r  <= acc_nxt;
      hs_r   <= hs_nxt;
      err_r  <= err_nxt;
    end
  end

  // error flag and swallow mode go together until the string ends
  a_err_swallow: assert property (@(posedge clk) disable iff (!rst_n)
    err_r == (mode_r == esu_pkg::M_SWALLOW))
    else $error("error flag out of step with swallow mode");

  a_nodata_single: assert property (@(posedge clk) disable iff (!rst_n)
    push_o && pkt_o.nodata |-> pkt_o.cnt == 3'd1)
    else $error("empty result packet with more than one entry");

endmodule

FILE: sv/esu_fifo.sv
// Small packet queue between the scanner and the byte emitter.
`timescale 1ns / 1ps

module esu_fifo #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_i,
  input  esu_pkg::pkt_t  pkt_i,
  input  logic           pop_i,
  output esu_pkg::pkt_t  head_o,
  output logic           empty_o,
  output logic           full_o
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  esu_pkg::pkt_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  assign empty_o = (count_r == '0);
  assign full_o  = (count_r == CW'(DEPTH));
  assign head_o  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push_i) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop_i) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push_i && !pop_i) count_nxt = count_r + CW'(1);
    else if (pop_i && !push_i) count_nxt = count_r - CW'(1);
  end

  always_ff @(posedge clk) begin
    if (push_i) mem_r[wr_ptr_r] <= pkt_i;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full_o |-> !push_i || pop_i)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    empty_o |-> !pop_i)
    else $error("pop from empty queue");

endmodule

FILE: sv/esu_back.sv
// Back end: plays queued packets out one result byte per cycle while out_stall is low.
`timescale 1ns / 1ps

module esu_back (
  input  logic           clk,
  input  logic           rst_n,
  input  esu_pkg::pkt_t  head_i,
  input  logic           empty_i,
  output logic           pop_o,
  output logic           out_valid,
  input  logic           out_stall,
  output logic [7:0]     out_byte_out,
  output logic           out_byte_valid,
  output logic           out_parse_error,
  output logic           out_end_of_string
);

  logic       out_valid_r, out_valid_nxt;
  logic [1:0] idx_r, idx_nxt;
  logic [7:0] byte_r;
  logic       bvalid_r, perr_r, eos_r;
  logic       adv;
  logic       load;
  logic       final_res;

  assign adv       = !out_valid_r || !out_stall;
  assign load      = adv && !empty_i;
  assign final_res = ({1'b0, idx_r} + 3'd1) == head_i.cnt;
  assign pop_o     = load && final_res;

  always_comb begin
    out_valid_nxt = out_valid_r;
    idx_nxt       = idx_r;
    if (adv) out_valid_nxt = !empty_i;
    if (load) idx_nxt = final_res ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      idx_r       <= 2'd0;
    end else begin
      out_valid_r <= out_valid_nxt;
      idx_r       <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r   <= head_i.nodata ? 8'd0 : head_i.data[idx_r];
      bvalid_r <= !head_i.nodata;
      perr_r   <= head_i.err && final_res;
      eos_r    <= head_i.eos && final_res;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_byte_out      = byte_r;
  assign out_byte_valid    = bvalid_r;
  assign out_parse_error   = perr_r;
  assign out_end_of_string = eos_r;

  a_idx_in_packet: assert property (@(posedge clk) disable iff (!rst_n)
    !empty_i |-> ({1'b0, idx_r} < head_i.cnt) && (head_i.cnt <= esu_pkg::MAX_RESULTS))
    else $error("result index beyond packet");

endmodule
